// ----- src/rfsw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsw_pkg: shared types and constants of the remote switch code encoder
// Command and result item types, the queued item descriptor, the fixed symbol
// strings and the Manchester and nibble helpers.
// ----------------------------------------------------------------------------
package rfsw_pkg;

  // Operation codes
  localparam logic [2:0] OP_ON    = 3'd0;
  localparam logic [2:0] OP_OFF   = 3'd1;
  localparam logic [2:0] OP_DIM   = 3'd2;
  localparam logic [2:0] OP_LEARN = 3'd3;

  // Device models
  localparam logic [1:0] MODEL_CODE   = 2'd0;
  localparam logic [1:0] MODEL_DIMMER = 2'd2;
  localparam logic [1:0] MODEL_BELL   = 2'd3;
  localparam logic [1:0] MODEL_RESET  = 2'd1;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODEL  = 2'd0;
  localparam logic [1:0] CFG_LETTER = 2'd1;
  localparam logic [1:0] CFG_HOUSE  = 2'd2;
  localparam logic [1:0] CFG_UNIT   = 2'd3;

  localparam int unsigned CFG_W   = 26;
  localparam int unsigned HOUSE_W = 26;

  // Command field of a self-learning frame
  localparam logic [1:0] CMD_ON  = 2'b10;
  localparam logic [1:0] CMD_OFF = 2'b01;
  localparam logic [1:0] CMD_DIM = 2'b00;

  // Symbol line: 73 symbols for a dim frame, 50 characters for a code frame
  localparam int unsigned SYM_W = 73;
  localparam int unsigned CODE_PAD_W = SYM_W - 50;

  // Index of the final byte for each frame kind
  localparam logic [5:0] CODE_LAST  = 6'd51;
  localparam logic [5:0] LEARN_LAST = 6'd39;
  localparam logic [5:0] DIM_LAST   = 6'd43;
  localparam logic [5:0] PULSE_IDX  = 6'd5;
  localparam logic [5:0] FIRST_IDX  = 6'd6;

  // Header and marker bytes
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_K      = 8'h6B;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] PULSE_DIM = 8'd147;
  localparam logic [7:0] PULSE_STD = 8'd132;
  localparam logic [3:0] FIRST_HI  = 4'h9;
  localparam logic [3:0] NIB_ONE   = 4'h8;
  localparam logic [3:0] NIB_ZERO  = 4'hA;

  // Fixed character strings, 'k' as one and '$' as zero, first character MSB
  localparam logic [17:0] ON_TAIL    = 18'b010101100110011001;
  localparam logic [17:0] OFF_TAIL   = 18'b010101100110010101;
  localparam logic [17:0] BELL_TAIL  = 18'b011001100110011001;
  localparam logic [15:0] UNIT7_TAIL = 16'b0110011001100101;
  localparam logic [3:0]  TUP_ONE    = 4'b0110;
  localparam logic [3:0]  TUP_ZERO   = 4'b0101;

  // Queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_UNSUP = 2'd0,
    MODE_CODE  = 2'd1,
    MODE_LEARN = 2'd2
  } mode_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] dim_level;
  } cmd_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
    logic       not_supported;
  } res_t;

  typedef struct packed {
    mode_e            mode;
    logic             dim;
    logic [SYM_W-1:0] sym;
  } desc_t;

  // Four characters per bit, bit 0 first
  function automatic logic [15:0] tuple4(input logic [3:0] v);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r[15-4*i -: 4] = v[i] ? TUP_ONE : TUP_ZERO;
    end
    return r;
  endfunction

  // Manchester code of the house bits, MSB first: one as 10, zero as 01
  function automatic logic [2*HOUSE_W-1:0] manch_house(input logic [HOUSE_W-1:0] v);
    logic [2*HOUSE_W-1:0] r;
    r = '0;
    for (int j = 0; j < HOUSE_W; j++) begin
      r[2*HOUSE_W-1-2*j -: 2] = {v[HOUSE_W-1-j], ~v[HOUSE_W-1-j]};
    end
    return r;
  endfunction

  function automatic logic [7:0] manch_nib(input logic [3:0] v);
    logic [7:0] r;
    r = '0;
    for (int j = 0; j < 4; j++) begin
      r[7-2*j -: 2] = {v[3-j], ~v[3-j]};
    end
    return r;
  endfunction

  function automatic logic [3:0] sym_nib(input logic s);
    return s ? NIB_ONE : NIB_ZERO;
  endfunction

  // Self-learning header bytes
  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = CH_T;
      3'd1:    r = 8'd127;
      3'd2:    r = 8'd255;
      3'd3:    r = 8'd24;
      default: r = 8'd1;
    endcase
    return r;
  endfunction

endpackage

// ----- src/rfsw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsw_front: configuration registers and command classification
// Holds the device registers and turns a command into a queue descriptor:
// frame kind, dim flag and the full symbol line the back end shifts out.
// ----------------------------------------------------------------------------
module rfsw_front
  import rfsw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  cmd_t             cmd_i,
  output desc_t            desc_o
);

  logic [1:0]         model_q;
  logic [3:0]         letter_q;
  logic [HOUSE_W-1:0] house_q;
  logic [3:0]         unit_q;

  mode_e            mode;
  logic [1:0]       cmd_bits;
  logic [3:0]       lvl;
  logic             is_dim;
  logic [SYM_W-1:0] learn_sym;
  logic [SYM_W-1:0] code_sym;
  logic [15:0]      second_tup;
  logic [17:0]      tail;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q  <= MODEL_RESET;
      letter_q <= '0;
      house_q  <= HOUSE_W'(1);
      unit_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODEL:  model_q  <= cfg_data_i[1:0];
        CFG_LETTER: letter_q <= cfg_data_i[3:0];
        CFG_HOUSE:  house_q  <= cfg_data_i[HOUSE_W-1:0];
        CFG_UNIT:   unit_q   <= cfg_data_i[3:0];
        default:    model_q  <= model_q;
      endcase
    end
  end

  // Classify the command
  always_comb begin
    mode     = MODE_UNSUP;
    is_dim   = 1'b0;
    cmd_bits = CMD_ON;
    lvl      = cmd_i.dim_level[7:4];
    if (model_q == MODEL_CODE) begin
      if (cmd_i.operation == OP_ON || cmd_i.operation == OP_OFF) begin
        mode = MODE_CODE;
      end
    end else if (model_q == MODEL_BELL) begin
      mode = MODE_CODE;
    end else if (cmd_i.operation == OP_ON && model_q == MODEL_DIMMER) begin
      mode     = MODE_LEARN;
      is_dim   = 1'b1;
      cmd_bits = CMD_DIM;
      lvl      = 4'hF;
    end else if (cmd_i.operation == OP_LEARN || cmd_i.operation == OP_ON) begin
      mode = MODE_LEARN;
    end else if (cmd_i.operation == OP_OFF) begin
      mode     = MODE_LEARN;
      cmd_bits = CMD_OFF;
    end else if (cmd_i.operation == OP_DIM) begin
      mode     = MODE_LEARN;
      is_dim   = 1'b1;
      cmd_bits = CMD_DIM;
    end
  end

  // Build the self-learning symbol line: house, group, command, unit, level, stop
  assign learn_sym = {manch_house(house_q), 2'b01, cmd_bits, manch_nib(unit_q),
                      is_dim ? manch_nib(lvl) : 8'h00, 1'b0};

  // Build the code-switch character line
  assign second_tup = (model_q == MODEL_BELL) ? UNIT7_TAIL : tuple4(unit_q);
  assign tail = (model_q == MODEL_BELL)     ? BELL_TAIL :
                (cmd_i.operation == OP_ON) ? ON_TAIL : OFF_TAIL;
  assign code_sym = {tuple4(letter_q), second_tup, tail, {CODE_PAD_W{1'b0}}};

  assign desc_o.mode = mode;
  assign desc_o.dim  = is_dim;
  assign desc_o.sym  = (mode == MODE_CODE) ? code_sym : learn_sym;

endmodule

// ----- src/rfsw_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsw_queue: descriptor queue between front and back
// Small register queue; full stalls the command port, empty idles the back.
// ----------------------------------------------------------------------------
module rfsw_queue
  import rfsw_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output desc_t head_o
);

  desc_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= desc_i;
    end
  end

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

endmodule

// ----- src/rfsw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsw_back: byte sequencer
// Loads one descriptor at a time and emits its byte string, one byte per
// clock, through a registered result port with a one-cycle strobe.
// ----------------------------------------------------------------------------
module rfsw_back
  import rfsw_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  desc_t head_i,
  output logic  pop_o,
  output logic  res_strobe_o,
  output res_t  res_o
);

  logic             act_q, act_d;
  mode_e            mode_q, mode_d;
  logic             dim_q, dim_d;
  logic [SYM_W-1:0] sh_q, sh_d;
  logic [5:0]       cnt_q, cnt_d;

  logic       strobe_q;
  res_t       res_q, res_d;
  logic [5:0] last_idx;
  logic       fin;

  // Find the final byte of the current item
  always_comb begin
    case (mode_q)
      MODE_CODE:  last_idx = CODE_LAST;
      MODE_LEARN: last_idx = dim_q ? DIM_LAST : LEARN_LAST;
      default:    last_idx = '0;
    endcase
  end

  assign fin   = act_q && (cnt_q == last_idx);
  assign pop_o = valid_i && (!act_q || fin);

  // Form the current byte
  always_comb begin
    res_d.code_byte     = CH_PLUS;
    res_d.last_byte     = fin;
    res_d.not_supported = 1'b0;
    case (mode_q)
      MODE_CODE: begin
        if (cnt_q == '0) begin
          res_d.code_byte = CH_S;
        end else if (!fin) begin
          res_d.code_byte = sh_q[SYM_W-1] ? CH_K : CH_DOLLAR;
        end
      end
      MODE_LEARN: begin
        if (cnt_q < PULSE_IDX) begin
          res_d.code_byte = hdr_byte(cnt_q[2:0]);
        end else if (cnt_q == PULSE_IDX) begin
          res_d.code_byte = dim_q ? PULSE_DIM : PULSE_STD;
        end else if (cnt_q == FIRST_IDX) begin
          res_d.code_byte = {FIRST_HI, sym_nib(sh_q[SYM_W-1])};
        end else if (!fin) begin
          res_d.code_byte = {sym_nib(sh_q[SYM_W-1]), sym_nib(sh_q[SYM_W-2])};
        end
      end
      default: begin
        res_d.code_byte     = 8'h00;
        res_d.not_supported = 1'b1;
      end
    endcase
  end

  // Advance the sequencer, load the next item as the last byte goes out
  always_comb begin
    act_d  = act_q;
    mode_d = mode_q;
    dim_d  = dim_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    if (pop_o) begin
      act_d  = 1'b1;
      mode_d = head_i.mode;
      dim_d  = head_i.dim;
      sh_d   = head_i.sym;
      cnt_d  = '0;
    end else if (fin) begin
      act_d = 1'b0;
    end else if (act_q) begin
      cnt_d = cnt_q + 6'd1;
      if (mode_q == MODE_CODE && cnt_q != '0) begin
        sh_d = sh_q << 1;
      end else if (mode_q == MODE_LEARN && cnt_q == FIRST_IDX) begin
        sh_d = sh_q << 1;
      end else if (mode_q == MODE_LEARN && cnt_q > FIRST_IDX) begin
        sh_d = sh_q << 2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      mode_q   <= MODE_UNSUP;
      dim_q    <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      act_q    <= act_d;
      mode_q   <= mode_d;
      dim_q    <= dim_d;
      cnt_q    <= cnt_d;
      strobe_q <= act_q;
    end
  end

  // Hold the symbol line and the result byte
  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    res_q <= res_d;
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

`ifndef SYNTH
  a_unsup_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && res_q.not_supported |-> res_q.last_byte && res_q.code_byte == 8'h00)
    else $error("unsupported item not a single zero byte");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> cnt_q <= CODE_LAST)
    else $error("byte index past the longest frame");

  a_item_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q && !fin |=> act_q && cnt_q == $past(cnt_q) + 6'd1)
    else $error("item stopped before its last byte");

  a_strobe_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |=> strobe_q)
    else $error("active cycle produced no result strobe");
`endif

endmodule

// ----- src/rf_remote_switch_code_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_remote_switch_code_encoder: 433 MHz remote switch command encoder
// Turns one switch command into the transmitter byte string for the
// configured device model.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. It passes through the
// queue and the byte sequencer, and the string comes out one byte per clock
// on res_o, each byte marked by res_strobe_o for one cycle; the receiver must
// take every byte as it appears. A code-switch or bell string is 52 bytes,
// a self-learning on, off or learn string 40, a dim string 44, and a command
// the model cannot encode gives a single zero byte flagged not_supported.
// The byte sequencer sets the rate at one byte per clock; a two-item queue
// ahead of it takes new commands while a string is still going out, and
// busy is high only while that queue is full. Write the configuration
// registers only while no string is pending.
// ----------------------------------------------------------------------------
module rf_remote_switch_code_encoder
  import rfsw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic             res_strobe_o,
  output res_t             res_o
);

  desc_t front_desc;
  desc_t head;
  logic  push;
  logic  pop;
  logic  full;
  logic  head_valid;

  assign push = start && !full;
  assign busy = full;

  // Classify commands
  rfsw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_i),
    .desc_o     (front_desc)
  );

  // Queue items between front and back
  rfsw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (front_desc),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (head)
  );

  // Emit bytes
  rfsw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule
